[sv/rtplk_pkg.sv]
// Shared types and constants for the route table prefix lookup core.
// Used by the command queue, the table engine and the top level.
// Depends on nothing.
package rtplk_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W = 8;
  localparam int CMD_W = 2;
  localparam int USED_W = 9;
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int Q_DEPTH = 2;
  localparam logic [WORD_W-1:0] MISS_HOP = 32'hffff_ffff;

  // Command codes as they arrive on the input channel.
  typedef enum logic [CMD_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } eng_state_t;

  // One classified command. key_a is the lookup address for a lookup and
  // the route mask for an add.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] key_a;
    logic [WORD_W-1:0] net;
    logic [WORD_W-1:0] hop;
    logic [IDX_W-1:0]  idx;
  } cmd_item_t;

endpackage

[sv/rtplk_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module rtplk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/rtplk_front.sv]
// Front end: takes input beats, classifies the command and holds it in a
// short queue for the table engine. Depends on rtplk_pkg.
module rtplk_front
  import rtplk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [WORD_W-1:0] in_lookup_addr,
  input  logic [WORD_W-1:0] in_entry_mask,
  input  logic [WORD_W-1:0] in_entry_net,
  input  logic [WORD_W-1:0] in_entry_hop,
  input  logic [IDX_W-1:0]  in_entry_index,
  output logic              q_valid,
  output cmd_item_t         q_item,
  input  logic              q_take
);

  localparam int QW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  cmd_item_t       slot_r [Q_DEPTH];
  logic [QW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  cmd_item_t       item_c;
  logic            push;

  // Classification: decode the command and keep only the operand it uses
  // in the shared key field.
  always_comb begin
    item_c.op    = op_t'(in_cmd);
    item_c.key_a = (op_t'(in_cmd) == OP_LOOKUP) ? in_lookup_addr : in_entry_mask;
    item_c.net   = in_entry_net;
    item_c.hop   = in_entry_hop;
    item_c.idx   = in_entry_index;
  end

  assign in_stall = (count_r == QC_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_take) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_take) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_take) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_c;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QC_W'(Q_DEPTH))
    else $error("command queue holds more beats than it has slots");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_take) |=> (count_r == QC_W'($past(count_r) + 1'b1)))
    else $error("queue count missed a push");

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("engine took a command from an empty queue");

endmodule

[sv/rtplk_engine.sv]
// Table engine: walks the route RAM for lookup, duplicate check and delete
// shift, keeps the fill count and the output register.
// Depends on rtplk_pkg and rtplk_ram.
module rtplk_engine
  import rtplk_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_item_t         q_item,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_op_ok,
  output logic [WORD_W-1:0] out_hop_out,
  output logic [USED_W-1:0] out_entries_used
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int RAM_W = 3 * WORD_W;

  eng_state_t        state_r, state_nxt;
  cmd_item_t         cur_r, cur_nxt;
  logic              fail_r, fail_nxt;
  logic              hit_r, hit_nxt;
  logic              dup_r, dup_nxt;
  logic [WORD_W-1:0] best_mask_r, best_mask_nxt;
  logic [WORD_W-1:0] best_hop_r, best_hop_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              dv_r, dv_nxt;
  logic [AW-1:0]     dst_r, dst_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [WORD_W-1:0] out_hop_r, out_hop_nxt;
  logic [USED_W-1:0] out_used_r, out_used_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic              read_en;
  logic [RAM_W-1:0]  ram_rdata;
  logic [WORD_W-1:0] rd_mask, rd_net, rd_hop;

  logic [CMP_W-1:0]  head_idx_c, fill_c, head_next_c;
  logic              idx_ok, idx_last, full_c, scan_done, out_free;
  logic              res_ok;
  logic [WORD_W-1:0] res_hop;
  logic [CNT_W-1:0]  fill_after;

  rtplk_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_route_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (read_en),
    .raddr (issue_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign {rd_mask, rd_net, rd_hop} = ram_rdata;

  assign head_idx_c  = CMP_W'(q_item.idx);
  assign fill_c      = CMP_W'(fill_r);
  assign head_next_c = head_idx_c + 1'b1;
  assign idx_ok      = head_idx_c < fill_c;
  assign idx_last    = head_next_c == fill_c;
  assign full_c      = fill_r == CNT_W'(TABLE_DEPTH);
  assign read_en     = ((state_r == ST_SCAN) || (state_r == ST_SHIFT)) && (issue_r != fill_r);
  assign scan_done   = (issue_r == fill_r) && !dv_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign q_take      = (state_r == ST_IDLE) && q_valid;

  // Result of the command held in cur_r, valid in ST_FINISH.
  always_comb begin
    res_ok     = 1'b0;
    res_hop    = MISS_HOP;
    fill_after = fill_r;
    unique case (cur_r.op)
      OP_LOOKUP: begin
        res_ok  = hit_r;
        res_hop = hit_r ? best_hop_r : MISS_HOP;
      end
      OP_ADD: begin
        res_ok = !fail_r && !dup_r;
        if (res_ok) begin
          fill_after = fill_r + 1'b1;
        end
      end
      OP_DELETE: begin
        res_ok = !fail_r;
        if (res_ok) begin
          fill_after = fill_r - 1'b1;
        end
      end
      OP_NONE: begin
        res_ok = 1'b0;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_LOOKUP: state_nxt = (fill_r == '0) ? ST_FINISH : ST_SCAN;
            OP_ADD:    state_nxt = (full_c || (fill_r == '0)) ? ST_FINISH : ST_SCAN;
            OP_DELETE: state_nxt = (!idx_ok || idx_last) ? ST_FINISH : ST_SHIFT;
            OP_NONE:   state_nxt = ST_FINISH;
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCAN, ST_SHIFT: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cur_nxt       = cur_r;
    fail_nxt      = fail_r;
    hit_nxt       = hit_r;
    dup_nxt       = dup_r;
    best_mask_nxt = best_mask_r;
    best_hop_nxt  = best_hop_r;
    issue_nxt     = issue_r;
    dv_nxt        = read_en;
    dst_nxt       = dst_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_hop_nxt   = out_hop_r;
    out_used_nxt  = out_used_r;
    ram_we        = 1'b0;
    ram_waddr     = dst_r;
    ram_wdata     = ram_rdata;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cur_nxt       = q_item;
          hit_nxt       = 1'b0;
          dup_nxt       = 1'b0;
          best_mask_nxt = '0;
          best_hop_nxt  = MISS_HOP;
          dst_nxt       = AW'(q_item.idx);
          issue_nxt     = '0;
          unique case (q_item.op)
            OP_LOOKUP: fail_nxt = 1'b0;
            OP_ADD:    fail_nxt = full_c;
            OP_DELETE: begin
              fail_nxt  = !idx_ok;
              issue_nxt = CNT_W'(head_next_c);
            end
            OP_NONE:   fail_nxt = 1'b1;
            default:   fail_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (read_en) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (dv_r) begin
          if (cur_r.op == OP_LOOKUP) begin
            if (((rd_mask & cur_r.key_a) == rd_net) && (!hit_r || (rd_mask >= best_mask_r))) begin
              hit_nxt       = 1'b1;
              best_mask_nxt = rd_mask;
              best_hop_nxt  = rd_hop;
            end
          end else if ((rd_mask == cur_r.key_a) && (rd_net == cur_r.net)
                       && (rd_hop == cur_r.hop)) begin
            dup_nxt = 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        if (read_en) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (dv_r) begin
          ram_we  = 1'b1;
          dst_nxt = dst_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok;
          out_hop_nxt   = res_hop;
          out_used_nxt  = USED_W'(fill_after);
          fill_nxt      = fill_after;
          if ((cur_r.op == OP_ADD) && res_ok) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[AW-1:0];
            ram_wdata = {cur_r.key_a, cur_r.net, cur_r.hop};
          end
        end
      end
      default: begin
        dv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    fail_r      <= fail_nxt;
    hit_r       <= hit_nxt;
    dup_r       <= dup_nxt;
    best_mask_r <= best_mask_nxt;
    best_hop_r  <= best_hop_nxt;
    issue_r     <= issue_nxt;
    dst_r       <= dst_nxt;
    out_ok_r    <= out_ok_nxt;
    out_hop_r   <= out_hop_nxt;
    out_used_r  <= out_used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_op_ok        = out_ok_r;
  assign out_hop_out      = out_hop_r;
  assign out_entries_used = out_used_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds the table depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_SHIFT) || (state_r == ST_FINISH)))
    else $error("route RAM written outside a shift or a finishing add");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && out_free && (cur_r.op == OP_ADD) && res_ok)
      |=> (fill_r == CNT_W'($past(fill_r) + 1'b1)))
    else $error("successful add did not grow the table");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished command did not post exactly one result");

endmodule

[sv/route_table_prefix_lookup_core.sv]
// Top level of the route table prefix lookup core.
// Depends on rtplk_pkg, rtplk_front and rtplk_engine (which holds rtplk_ram).

// The core keeps a table of up to TABLE_DEPTH routes, each a mask, a network
// and a next hop, in one RAM of 96-bit words. Every input beat carries one
// command: a lookup returns the next hop of the matching route with the
// largest mask (the later route wins a tie, all ones on a miss); an add
// appends a route unless the table is full or the same route is already
// present; a delete removes the route at the given position and moves the
// later routes down. Each command yields exactly one result beat, which also
// reports the number of routes held afterwards. A small two-beat queue takes
// commands in while the engine is busy, and the result sits in an output
// register, so the input keeps accepting commands until that queue is full
// while a result waits to be taken. The engine walks the RAM one route per
// cycle through its single read port. A lookup or an add on a table of N
// routes reads all N routes, and a delete at position i below the last route
// moves the N - i - 1 routes above it. A command that needs no walk (a full
// or empty table, a bad position, a delete of the last route, the unused
// code) goes straight to its result. The RAM needs no clearing after reset,
// since only routes below the fill count are read.
module route_table_prefix_lookup_core
  import rtplk_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [WORD_W-1:0] in_lookup_addr,
  input  logic [WORD_W-1:0] in_entry_mask,
  input  logic [WORD_W-1:0] in_entry_net,
  input  logic [WORD_W-1:0] in_entry_hop,
  input  logic [IDX_W-1:0]  in_entry_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_op_ok,
  output logic [WORD_W-1:0] out_hop_out,
  output logic [USED_W-1:0] out_entries_used
);

  // Classified commands between the queue and the engine.
  logic      q_valid;
  logic      q_take;
  cmd_item_t q_item;

  rtplk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_lookup_addr (in_lookup_addr),
    .in_entry_mask  (in_entry_mask),
    .in_entry_net   (in_entry_net),
    .in_entry_hop   (in_entry_hop),
    .in_entry_index (in_entry_index),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_take         (q_take)
  );

  // The engine owns the route RAM, the fill count and the result register.
  rtplk_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_take           (q_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_op_ok        (out_op_ok),
    .out_hop_out      (out_hop_out),
    .out_entries_used (out_entries_used)
  );

endmodule

[test/tb_route_table_prefix_lookup_core.sv]
// Self-checking testbench for route_table_prefix_lookup_core: a scoreboard class predicts
// every result beat, and plain tasks drive lookups, adds and deletes under random idling.
// Depends on rtplk_pkg and the route_table_prefix_lookup_core RTL.
module tb_route_table_prefix_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rtplk_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  // The slowest command walks the whole table, and receiver bursts and the long hold-off
  // are far shorter than QUIET_LIMIT, so a quiet stretch that long can only mean the block
  // has hung.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 300;

  // One expected result beat.
  typedef struct {
    logic              ok;
    logic [WORD_W-1:0] hop;
    logic [USED_W-1:0] used;
  } route_result_t;

  // Shadow copy of the route table. Every accepted command beat updates it and queues the
  // result beat the block must produce; result beats are then checked in order.
  class route_scoreboard;
    logic [WORD_W-1:0] mask_tab [TABLE_DEPTH];
    logic [WORD_W-1:0] net_tab [TABLE_DEPTH];
    logic [WORD_W-1:0] hop_tab [TABLE_DEPTH];
    int unsigned       fill;
    route_result_t     result_q[$];
    int unsigned       mismatches;
    int unsigned       n_cmd, n_lookup, n_hit, n_add, n_add_full, n_delete, n_delete_ok;
    int unsigned       peak;

    function int pending();
      return result_q.size();
    endfunction

    function void note_command(op_t op, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] m,
                               logic [WORD_W-1:0] n, logic [WORD_W-1:0] h,
                               logic [IDX_W-1:0] idx);
      route_result_t     res;
      logic [WORD_W-1:0] best_mask;
      bit                dup;
      res.ok  = 1'b0;
      res.hop = MISS_HOP;
      n_cmd++;
      case (op)
        OP_LOOKUP: begin
          // Largest mask wins; on equal masks the later route replaces the earlier one.
          n_lookup++;
          best_mask = '0;
          for (int k = 0; k < fill; k++) begin
            if ((mask_tab[k] & addr) == net_tab[k] && (!res.ok || mask_tab[k] >= best_mask)) begin
              res.ok    = 1'b1;
              best_mask = mask_tab[k];
              res.hop   = hop_tab[k];
            end
          end
          if (res.ok) n_hit++;
        end
        OP_ADD: begin
          n_add++;
          dup = 1'b0;
          for (int k = 0; k < fill; k++) begin
            if (mask_tab[k] == m && net_tab[k] == n && hop_tab[k] == h) dup = 1'b1;
          end
          if (fill >= TABLE_DEPTH) begin
            n_add_full++;
          end else if (!dup) begin
            mask_tab[fill] = m;
            net_tab[fill]  = n;
            hop_tab[fill]  = h;
            fill++;
            res.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          n_delete++;
          if (idx < fill) begin
            for (int k = idx; k + 1 < fill; k++) begin
              mask_tab[k] = mask_tab[k + 1];
              net_tab[k]  = net_tab[k + 1];
              hop_tab[k]  = hop_tab[k + 1];
            end
            fill--;
            res.ok = 1'b1;
            n_delete_ok++;
          end
        end
        default: ;
      endcase
      if (fill > peak) peak = fill;
      res.used = fill[USED_W-1:0];
      result_q.push_back(res);
    endfunction

    function void check_result(logic ok, logic [WORD_W-1:0] hop, logic [USED_W-1:0] used);
      route_result_t exp_res;
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: op_ok %0b hop_out %h entries_used %0d",
               ok, hop, used);
        mismatches++;
        return;
      end
      exp_res = result_q.pop_front();
      if (ok !== exp_res.ok) begin
        $error("op_ok mismatch: expected %0b, actual %0b", exp_res.ok, ok);
        mismatches++;
      end
      if (hop !== exp_res.hop) begin
        $error("hop_out mismatch: expected %h, actual %h", exp_res.hop, hop);
        mismatches++;
      end
      if (used !== exp_res.used) begin
        $error("entries_used mismatch: expected %0d, actual %0d", exp_res.used, used);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd;
  logic [WORD_W-1:0] in_lookup_addr;
  logic [WORD_W-1:0] in_entry_mask;
  logic [WORD_W-1:0] in_entry_net;
  logic [WORD_W-1:0] in_entry_hop;
  logic [IDX_W-1:0]  in_entry_index;
  logic              out_valid;
  logic              out_stall;
  logic              out_op_ok;
  logic [WORD_W-1:0] out_hop_out;
  logic [USED_W-1:0] out_entries_used;

  route_scoreboard sb = new;

  // Idling controls: src_jitter lets the sender leave gaps, sink_jitter lets the receiver
  // stall in bursts, and hold_req asks the receiver process for one long hold-off.
  bit src_jitter;
  bit sink_jitter;
  bit hold_req;
  int quiet_cycles;

  route_table_prefix_lookup_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_lookup_addr  (in_lookup_addr),
    .in_entry_mask   (in_entry_mask),
    .in_entry_net    (in_entry_net),
    .in_entry_hop    (in_entry_hop),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op_ok       (out_op_ok),
    .out_hop_out     (out_hop_out),
    .out_entries_used(out_entries_used)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result beats are sampled at the rising edge, where the stall seen is the one the
  // block saw too, since the receiver only changes it at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_op_ok, out_hop_out,
                                                          out_entries_used);
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts while sink_jitter is set, and one long hold-off, counted
  // here, whenever the stimulus asks for it. Exactly one assignment to out_stall is made at
  // each falling edge.
  initial begin : receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall = 1'b1;
        burst_left--;
      end else if (sink_jitter && $urandom_range(0, 19) == 0) begin
        out_stall = 1'b1;
        burst_left = $urandom_range(1, 12) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offers one command beat from a falling edge and returns at the falling edge after it
  // has been accepted, with in_valid still high so that a following beat can go straight
  // out.
  task automatic send_command(input op_t op, input logic [WORD_W-1:0] addr,
                              input logic [WORD_W-1:0] m, input logic [WORD_W-1:0] n,
                              input logic [WORD_W-1:0] h, input logic [IDX_W-1:0] idx);
    in_valid       = 1'b1;
    in_cmd         = op;
    in_lookup_addr = addr;
    in_entry_mask  = m;
    in_entry_net   = n;
    in_entry_hop   = h;
    in_entry_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(op, addr, m, n, h, idx);
    @(negedge clk);
  endtask

  task automatic source_gap();
    if (src_jitter && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // The sender stops until the block has returned every outstanding result.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Most lookup addresses are aimed at a stored route, so that hits, nested prefixes and
  // ties are common; some of those have one random bit flipped, the rest are random.
  function automatic logic [WORD_W-1:0] pick_address(logic [WORD_W-1:0] noise);
    logic [WORD_W-1:0] addr;
    int                k;
    if (sb.fill == 0 || $urandom_range(0, 9) < 3) return noise;
    k = $urandom_range(0, sb.fill - 1);
    addr = (sb.net_tab[k] & sb.mask_tab[k]) | (noise & ~sb.mask_tab[k]);
    if ($urandom_range(0, 7) == 0) addr ^= 32'h1 << $urandom_range(0, 31);
    return addr;
  endfunction

  // Routes are mostly proper prefixes, many drawn around a few shared networks, with exact
  // duplicates, same-prefix routes with a new hop and arbitrary mask patterns mixed in.
  task automatic pick_route(output logic [WORD_W-1:0] m, output logic [WORD_W-1:0] n,
                            output logic [WORD_W-1:0] h);
    int c;
    int k;
    int len;
    c = $urandom_range(0, 99);
    h = $urandom;
    if (sb.fill > 0 && c < 15) begin
      k = $urandom_range(0, sb.fill - 1);
      m = sb.mask_tab[k];
      n = sb.net_tab[k];
      if (c < 8) h = sb.hop_tab[k];
    end else if (c < 20) begin
      m = $urandom;
      n = $urandom;
    end else begin
      len = $urandom_range(0, 32);
      m = 32'hffff_ffff << (32 - len);
      if (c < 60) n = {8'd10, 8'($urandom_range(0, 3)), 16'($urandom)} & m;
      else n = $urandom & m;
    end
  endtask

  // Delete positions: mostly valid, sometimes just past the end or anywhere in range.
  function automatic logic [IDX_W-1:0] pick_position(logic [IDX_W-1:0] noise);
    int c;
    c = $urandom_range(0, 9);
    if (sb.fill > 0 && c < 8) return IDX_W'($urandom_range(0, sb.fill - 1));
    if (sb.fill < TABLE_DEPTH && c == 8) return IDX_W'(sb.fill);
    return noise;
  endfunction

  // A mix of all commands that steers the table towards a target size: adds dominate
  // below it and deletes above it.
  task automatic run_mixed(input int count, input int target);
    op_t               op;
    logic [WORD_W-1:0] a, m, n, h;
    logic [IDX_W-1:0]  ix;
    int                r;
    for (int i = 0; i < count; i++) begin
      a  = $urandom;
      m  = $urandom;
      n  = $urandom;
      h  = $urandom;
      ix = $urandom;
      r  = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_NONE;
      end else if (r < 43) begin
        op = OP_LOOKUP;
        a = pick_address(a);
      end else if ((sb.fill < target) ? (r < 85) : (r < 55)) begin
        op = OP_ADD;
        pick_route(m, n, h);
      end else begin
        op = OP_DELETE;
        ix = pick_position(ix);
      end
      send_command(op, a, m, n, h, ix);
      source_gap();
    end
  endtask

  // Adds routes until the table is full; duplicates that slip in are simply refused.
  task automatic fill_table();
    logic [WORD_W-1:0] m, n, h;
    while (sb.fill < TABLE_DEPTH) begin
      pick_route(m, n, h);
      send_command(OP_ADD, $urandom, m, n, h, IDX_W'($urandom));
      source_gap();
    end
  endtask

  // Shrinks a large table with in-range deletes, with lookups in between.
  task automatic drain_table(input int floor_size);
    while (sb.fill > floor_size) begin
      if ($urandom_range(0, 4) == 0) begin
        send_command(OP_LOOKUP, pick_address($urandom), $urandom, $urandom, $urandom,
                     IDX_W'($urandom));
      end else begin
        send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom,
                     IDX_W'($urandom_range(0, sb.fill - 1)));
      end
      source_gap();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = OP_NONE;
    in_lookup_addr = '0;
    in_entry_mask  = '0;
    in_entry_net   = '0;
    in_entry_hop   = '0;
    in_entry_index = '0;
    src_jitter     = 1'b0;
    sink_jitter    = 1'b0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: commands on an empty table, the default route, host routes with a
    // tie, a duplicate, a mask that is not a prefix, a network that can never match,
    // deletes at the front, the back, the middle and out of range, and the unused code.
    send_command(OP_LOOKUP, 32'h0a00_0001, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, 8'd0);
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, 8'hff);
    send_command(OP_NONE, $urandom, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'h0, 32'h0, 32'h0a00_0001, IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'hffff_ffff, 32'hffff_ffff, 32'h0, IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'hffff_ffff, 32'hffff_ffff, 32'h0, IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'hffff_ff00, 32'hc0a8_0100, 32'h1, IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'hf0f0_f0f0, 32'h1020_3040, 32'h2, IDX_W'($urandom));
    send_command(OP_ADD, $urandom, 32'h0000_ffff, 32'h0001_0000, 32'h3, IDX_W'($urandom));
    send_command(OP_LOOKUP, 32'hffff_ffff, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_LOOKUP, 32'hc0a8_0155, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_LOOKUP, 32'h0, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_LOOKUP, 32'h1a2b_3c4d, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_LOOKUP, 32'h0001_0000, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, IDX_W'(sb.fill));
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, 8'd0);
    send_command(OP_LOOKUP, 32'h0, $urandom, $urandom, $urandom, IDX_W'($urandom));
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, IDX_W'(sb.fill - 1));
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, 8'd1);
    send_command(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    send_command(OP_DELETE, $urandom, $urandom, $urandom, $urandom, 8'hff);
    wait_for_results();

    // Random part on a small table, first with idling on both sides.
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    run_mixed(300, 8);

    // The receiver holds off for a long stretch while the sender keeps offering beats,
    // so the command queue and the output register fill and the input stalls.
    src_jitter = 1'b0;
    hold_req   = 1'b1;
    run_mixed(40, 4);

    // A stretch with no idling at all, then a pause until every result is back.
    sink_jitter = 1'b0;
    run_mixed(200, 24);
    wait_for_results();

    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    run_mixed(150, 64);
    wait_for_results();

    // Full table: adds are refused, deletes shift long runs and lookups walk every route.
    fill_table();
    run_mixed(80, TABLE_DEPTH + 1);
    drain_table(16);
    run_mixed(200, 12);

    // Closing stretch without idling on either side.
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    run_mixed(150, 10);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d commands: %0d lookups (%0d hits), %0d adds (%0d on a full table),",
             sb.n_cmd, sb.n_lookup, sb.n_hit, sb.n_add, sb.n_add_full);
    $display("%0d deletes (%0d done), peak table size %0d, %0d mismatching fields.",
             sb.n_delete, sb.n_delete_ok, sb.peak, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
